// File: rtl/tfc_pkg.sv
package tfc_pkg;

  // Field widths of the transaction payloads
  localparam int unsigned SAMPLE_BITS = 10;
  localparam int unsigned CMD_BITS    = 2;
  localparam int unsigned RIDX_BITS   = 8;

  // Configuration port
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 20;

  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_PERIOD = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_LENGTH = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BLINK_PERIOD = 2'd2;

  localparam logic [15:0] FRAME_PERIOD_RST = 16'd1417;
  localparam logic [8:0]  FRAME_LENGTH_RST = 9'd256;
  localparam logic [19:0] BLINK_PERIOD_RST = 20'd21250;

  // Commands
  localparam logic [CMD_BITS-1:0] CMD_TICK    = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_READ    = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_RELEASE = 2'd2;

  // Capture phase codes as reported on the result
  localparam logic [1:0] PHASE_CODE_IDLE   = 2'd0;
  localparam logic [1:0] PHASE_CODE_ARMED  = 2'd1;
  localparam logic [1:0] PHASE_CODE_RECORD = 2'd2;

  typedef struct packed {
    logic [CMD_BITS-1:0]    command;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   phase_wrapped;
    logic [RIDX_BITS-1:0]   read_index;
  } in_item_t;

  typedef struct packed {
    logic                   led_level;
    logic                   frame_ready;
    logic                   ready_half;
    logic [SAMPLE_BITS-1:0] read_sample;
    logic [1:0]             capture_phase;
  } out_item_t;

endpackage

// File: rtl/tfc_ram.sv
module tfc_ram #(
  parameter int unsigned Width = 10,
  parameter int unsigned Depth = 512
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/triggered_frame_capture_core.sv
// Channel  | Direction | Handshake             | Payload
// in       | input     | in_valid_i/in_ready_o | in_item_i  (command, sample, wrap, index)
// out      | output    | out_valid_o/out_ready_i | out_item_o (status, read sample)
// cfg      | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One transaction per cycle is accepted while the store clear is done and the read
// stage is free or advancing; its result passes through the registered store read
// and then the output register. After reset the store is cleared one entry per cycle,
// with in_ready_o low; configuration writes are taken throughout.
// A stalled output holds in the output register while one more transaction enters the
// read stage; further input waits until the output drains.
module triggered_frame_capture_core #(
  parameter int unsigned FRAME_DEPTH = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  tfc_pkg::in_item_t                   in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output tfc_pkg::out_item_t                  out_item_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tfc_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [tfc_pkg::CFG_DATA_BITS-1:0]   cfg_data_i
);
  import tfc_pkg::*;

  localparam int unsigned StoreDepth = 2 * FRAME_DEPTH;
  localparam int unsigned AddrW      = $clog2(StoreDepth);
  localparam int unsigned PosW       = $clog2(FRAME_DEPTH + 1);
  localparam int unsigned LenW       = (PosW > 9) ? PosW : 9;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_ARMED  = 3'b010,
    PH_RECORD = 3'b100
  } phase_e;

  // Configuration registers
  logic [15:0] frame_period_q;
  logic [8:0]  frame_length_q;
  logic [19:0] blink_period_q;

  // Control state
  logic [15:0]     frame_cnt_q, frame_cnt_d;
  logic [19:0]     blink_cnt_q, blink_cnt_d;
  logic            led_q, led_d;
  phase_e          phase_q, phase_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            write_half_q, write_half_d;
  logic            pend_q, pend_d;
  logic            pend_half_q, pend_half_d;

  // Store clearing after reset
  logic             clr_busy_q;
  logic [AddrW-1:0] clr_addr_q;

  // Read stage and output register
  logic       a_valid_q;
  logic       a_is_read_q;
  out_item_t  a_item_q;
  logic       o_valid_q;
  out_item_t  o_item_q;
  out_item_t  o_item_d;

  logic accept;
  logic a_adv;

  // Store port
  logic                   ram_en;
  logic                   ram_we;
  logic [AddrW-1:0]       ram_addr;
  logic [SAMPLE_BITS-1:0] ram_wdata;
  logic [SAMPLE_BITS-1:0] ram_rdata;

  // Per-transaction datapath
  logic [15:0]     frame_next;
  logic            frame_fire;
  logic [19:0]     blink_next;
  logic            blink_fire;
  logic [LenW-1:0] len_ext;
  logic [LenW-1:0] len_eff;
  logic [PosW-1:0] pos_inc;
  logic            do_write;
  logic            do_read;
  logic [AddrW-1:0] wr_addr;
  logic [AddrW-1:0] rd_addr;
  logic [1:0]      phase_code;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_period_q <= FRAME_PERIOD_RST;
      frame_length_q <= FRAME_LENGTH_RST;
      blink_period_q <= BLINK_PERIOD_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FRAME_PERIOD: frame_period_q <= cfg_data_i[15:0];
        REG_FRAME_LENGTH: frame_length_q <= cfg_data_i[8:0];
        REG_BLINK_PERIOD: blink_period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign a_adv      = !o_valid_q || out_ready_i;
  assign in_ready_o = !clr_busy_q && (!a_valid_q || a_adv);
  assign accept     = in_valid_i && in_ready_o;

  // Period counters: fire when the incremented count reaches the period or wraps
  assign frame_next = frame_cnt_q + 16'd1;
  assign frame_fire = (frame_next >= frame_period_q) || (frame_next == 16'd0);
  assign blink_next = blink_cnt_q + 20'd1;
  assign blink_fire = (blink_next >= blink_period_q) || (blink_next == 20'd0);

  // Frame length clamped to 1..FRAME_DEPTH
  assign len_ext = LenW'(frame_length_q);
  always_comb begin
    if (frame_length_q == 9'd0) begin
      len_eff = LenW'(1);
    end else if (len_ext > LenW'(FRAME_DEPTH)) begin
      len_eff = LenW'(FRAME_DEPTH);
    end else begin
      len_eff = len_ext;
    end
  end

  always_comb begin
    frame_cnt_d  = frame_cnt_q;
    blink_cnt_d  = blink_cnt_q;
    led_d        = led_q;
    phase_d      = phase_q;
    pos_d        = pos_q;
    write_half_d = write_half_q;
    pend_d       = pend_q;
    pend_half_d  = pend_half_q;
    do_write     = 1'b0;
    do_read      = 1'b0;
    wr_addr      = '0;
    pos_inc      = '0;
    if (accept) begin
      case (in_item_i.command)
        CMD_TICK: begin
          blink_cnt_d = blink_fire ? 20'd0 : blink_next;
          frame_cnt_d = frame_fire ? 16'd0 : frame_next;
          if (blink_fire) begin
            led_d = !led_q;
          end
          if (frame_fire && phase_q == PH_IDLE && !pend_q) begin
            phase_d = PH_ARMED;
          end
          if (phase_d == PH_ARMED && in_item_i.phase_wrapped) begin
            phase_d = PH_RECORD;
            pos_d   = '0;
          end
          if (phase_d == PH_RECORD) begin
            do_write = 1'b1;
            wr_addr  = write_half_q ? AddrW'(FRAME_DEPTH) + AddrW'(pos_d) : AddrW'(pos_d);
            pos_inc  = pos_d + PosW'(1);
            pos_d    = pos_inc;
            if (LenW'(pos_inc) >= len_eff) begin
              phase_d      = PH_IDLE;
              pend_half_d  = write_half_q;
              pend_d       = 1'b1;
              write_half_d = !write_half_q;
            end
          end
        end
        CMD_READ: begin
          do_read = ({24'd0, in_item_i.read_index} < 32'(FRAME_DEPTH));
        end
        CMD_RELEASE: begin
          pend_d = 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign rd_addr = pend_half_q ? AddrW'(FRAME_DEPTH) + AddrW'(in_item_i.read_index)
                               : AddrW'(in_item_i.read_index);

  always_comb begin
    case (phase_d)
      PH_IDLE:   phase_code = PHASE_CODE_IDLE;
      PH_ARMED:  phase_code = PHASE_CODE_ARMED;
      PH_RECORD: phase_code = PHASE_CODE_RECORD;
      default:   phase_code = PHASE_CODE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_cnt_q  <= '0;
      blink_cnt_q  <= '0;
      led_q        <= 1'b0;
      phase_q      <= PH_IDLE;
      pos_q        <= '0;
      write_half_q <= 1'b0;
      pend_q       <= 1'b0;
      pend_half_q  <= 1'b0;
    end else begin
      frame_cnt_q  <= frame_cnt_d;
      blink_cnt_q  <= blink_cnt_d;
      led_q        <= led_d;
      phase_q      <= phase_d;
      pos_q        <= pos_d;
      write_half_q <= write_half_d;
      pend_q       <= pend_d;
      pend_half_q  <= pend_half_d;
    end
  end

  // Sweep zeros through the store, then open the input
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + AddrW'(1);
      if (clr_addr_q == AddrW'(StoreDepth - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  assign ram_en    = clr_busy_q || do_write || do_read;
  assign ram_we    = clr_busy_q || do_write;
  assign ram_addr  = clr_busy_q ? clr_addr_q : (do_write ? wr_addr : rd_addr);
  assign ram_wdata = clr_busy_q ? '0 : in_item_i.sample;

  tfc_ram #(
    .Width (SAMPLE_BITS),
    .Depth (StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Read stage: status after the step, store data arrives next cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_ready_o || clr_busy_q) begin
      a_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_is_read_q              <= do_read;
      a_item_q.led_level       <= led_d;
      a_item_q.frame_ready     <= pend_d;
      a_item_q.ready_half      <= pend_half_d;
      a_item_q.read_sample     <= '0;
      a_item_q.capture_phase   <= phase_code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (a_adv) begin
      o_valid_q <= a_valid_q;
    end
  end

  always_comb begin
    o_item_d             = a_item_q;
    o_item_d.read_sample = a_is_read_q ? ram_rdata : '0;
  end

  always_ff @(posedge clk_i) begin
    if (a_adv && a_valid_q) begin
      o_item_q <= o_item_d;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_item_o  = o_item_q;

endmodule

// File: rtl/tfc_checker.sv
module tfc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input tfc_pkg::out_item_t out_item_o
);
  import tfc_pkg::*;

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_item_o))
    else $error("stalled result changed");

  // No capture can be armed or running while a completed frame is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.frame_ready |-> out_item_o.capture_phase == PHASE_CODE_IDLE)
    else $error("capture active while a frame is pending");

  // A fresh result traces back to a transaction that was accepted into the read stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !$past(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without an accepted transaction");

endmodule

bind triggered_frame_capture_core tfc_checker u_tfc_checker (.*);

// File: tb/sv/triggered_frame_capture_core_tb.sv
`timescale 1ns / 1ps
module triggered_frame_capture_core_tb;
  import tfc_pkg::*;

  localparam int unsigned FRAME_DEPTH = 256;
  localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned IDLE_PERCENT = 19;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned LONG_HOLD_AFTER = 1100;
  localparam int unsigned ITEMS_PER_PHASE = 220;
  localparam int unsigned RANDOM_PHASES = 9;

  class capture_scoreboard;
    logic [15:0] frame_period;
    logic [8:0] frame_length;
    logic [19:0] blink_period;
    logic [15:0] frame_count;
    logic [19:0] blink_count;
    logic led;
    logic [1:0] phase;
    logic [8:0] write_pos;
    logic write_half;
    logic frame_ready;
    logic ready_half;
    logic [SAMPLE_BITS-1:0] sample_store [2*FRAME_DEPTH];
    out_item_t expected_status[$];
    int unsigned mismatches;

    function new();
      frame_period = FRAME_PERIOD_RST;
      frame_length = FRAME_LENGTH_RST;
      blink_period = BLINK_PERIOD_RST;
      frame_count = '0;
      blink_count = '0;
      led = 1'b0;
      phase = PHASE_CODE_IDLE;
      write_pos = '0;
      write_half = 1'b0;
      frame_ready = 1'b0;
      ready_half = 1'b0;
      foreach (sample_store[i]) sample_store[i] = '0;
      mismatches = 0;
    endfunction

    function void write_register(logic [CFG_IDX_BITS-1:0] index,
                                 logic [CFG_DATA_BITS-1:0] value);
      case (index)
        REG_FRAME_PERIOD: frame_period = value[15:0];
        REG_FRAME_LENGTH: frame_length = value[8:0];
        REG_BLINK_PERIOD: blink_period = value[19:0];
        default: ;
      endcase
    endfunction

    // Advance the capture state for one transaction and queue the status it yields.
    function void predict_status(in_item_t item);
      out_item_t status;
      logic [15:0] frame_next;
      logic [19:0] blink_next;
      logic [8:0] length;
      status = '0;
      case (item.command)
        CMD_TICK: begin
          blink_next = blink_count + 20'd1;
          if (blink_next >= blink_period || blink_next == '0) begin
            blink_count = '0;
            led = ~led;
          end else begin
            blink_count = blink_next;
          end
          frame_next = frame_count + 16'd1;
          if (frame_next >= frame_period || frame_next == '0) begin
            frame_count = '0;
            if (phase == PHASE_CODE_IDLE && !frame_ready) phase = PHASE_CODE_ARMED;
          end else begin
            frame_count = frame_next;
          end
          if (phase == PHASE_CODE_ARMED && item.phase_wrapped) begin
            phase = PHASE_CODE_RECORD;
            write_pos = '0;
          end
          if (phase == PHASE_CODE_RECORD) begin
            if (write_pos < FRAME_DEPTH) sample_store[{write_half, write_pos[7:0]}] = item.sample;
            write_pos = write_pos + 9'd1;
            length = frame_length;
            if (length == '0) length = 9'd1;
            if (length > FRAME_DEPTH) length = 9'(FRAME_DEPTH);
            if (write_pos >= length) begin
              phase = PHASE_CODE_IDLE;
              ready_half = write_half;
              frame_ready = 1'b1;
              write_half = ~write_half;
            end
          end
        end
        CMD_READ: status.read_sample = sample_store[{ready_half, item.read_index}];
        CMD_RELEASE: frame_ready = 1'b0;
        default: ;
      endcase
      status.led_level = led;
      status.frame_ready = frame_ready;
      status.ready_half = ready_half;
      status.capture_phase = phase;
      expected_status.push_back(status);
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        mismatches++;
      end
    endfunction

    function void check_status(out_item_t actual);
      out_item_t want;
      if (expected_status.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual %p", $time, actual);
        mismatches++;
        return;
      end
      want = expected_status.pop_front();
      compare_field("led_level", want.led_level, actual.led_level);
      compare_field("frame_ready", want.frame_ready, actual.frame_ready);
      compare_field("ready_half", want.ready_half, actual.ready_half);
      compare_field("read_sample", want.read_sample, actual.read_sample);
      compare_field("capture_phase", want.capture_phase, actual.capture_phase);
    endfunction

    function int unsigned outstanding();
      return expected_status.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready_o;
  in_item_t in_item = '0;
  logic out_valid_o;
  logic out_ready = 1'b0;
  out_item_t out_item_o;
  logic cfg_valid = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  bit steady_run = 1'b0;
  int unsigned inputs_accepted = 0;
  int unsigned quiet_cycles = 0;
  capture_scoreboard sb = new();

  triggered_frame_capture_core #(
    .FRAME_DEPTH(FRAME_DEPTH)
  ) DUT (
    .clk_i(clk),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid),
    .in_ready_o(in_ready_o),
    .in_item_i(in_item),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_item_o(out_item_o),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Track every transaction and bail out if the block goes quiet for too long.
  always @(posedge clk) begin
    if (rst_ni) begin
      if (cfg_valid && cfg_ready_o) sb.write_register(cfg_index, cfg_data);
      if (in_valid && in_ready_o) begin
        sb.predict_status(in_item);
        inputs_accepted++;
      end
      if (out_valid_o && out_ready) sb.check_status(out_item_o);
      if ((cfg_valid && cfg_ready_o) || (in_valid && in_ready_o) ||
          (out_valid_o && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("CHECK FAILED");
          $finish;
        end
      end
    end
  end

  // Result side: random back-pressure plus one long hold-off mid-run.
  initial begin
    int unsigned hold_left;
    bit long_hold_done;
    hold_left = 0;
    long_hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!long_hold_done && inputs_accepted >= LONG_HOLD_AFTER) begin
        hold_left = LONG_HOLD_CYCLES;
        long_hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= steady_run || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  task automatic send_command(logic [CMD_BITS-1:0] cmd_code, logic [SAMPLE_BITS-1:0] sample_value,
                              logic wrap, logic [RIDX_BITS-1:0] index);
    if (!steady_run) begin
      while ($urandom_range(99) < IDLE_PERCENT) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_item <= '{command: cmd_code, sample: sample_value, phase_wrapped: wrap,
                 read_index: index};
    do @(posedge clk); while (!in_ready_o);
    @(negedge clk);
  endtask

  task automatic send_random_command();
    int unsigned pick;
    logic [CMD_BITS-1:0] cmd_code;
    pick = $urandom_range(99);
    if (pick < 72) cmd_code = CMD_TICK;
    else if (pick < 87) cmd_code = CMD_READ;
    else if (pick < 96) cmd_code = CMD_RELEASE;
    else cmd_code = CMD_UNUSED;
    send_command(cmd_code, SAMPLE_BITS'($urandom_range(1023)), $urandom_range(3) == 0,
                 RIDX_BITS'($urandom_range(255)));
  endtask

  // Hold the input idle until every queued status has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_BITS-1:0] index, logic [CFG_DATA_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready_o);
    @(negedge clk);
  endtask

  task automatic program_capture(logic [15:0] period, logic [8:0] length, logic [19:0] blink);
    write_cfg(REG_FRAME_PERIOD, CFG_DATA_BITS'(period));
    write_cfg(REG_FRAME_LENGTH, CFG_DATA_BITS'(length));
    write_cfg(REG_BLINK_PERIOD, blink);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    // Zero periods fire every tick; zero length records a single sample.
    write_cfg(REG_UNUSED, '1);
    program_capture(16'd0, 9'd0, 20'd0);
    send_command(CMD_TICK, 10'd0, 1'b0, 8'd0);
    send_command(CMD_TICK, 10'h3FF, 1'b1, 8'hFF);
    send_command(CMD_READ, 10'd0, 1'b0, 8'd0);
    send_command(CMD_READ, 10'h3FF, 1'b1, 8'hFF);
    send_command(CMD_TICK, 10'd5, 1'b1, 8'd0);
    send_command(CMD_UNUSED, 10'h3FF, 1'b1, 8'hFF);
    send_command(CMD_RELEASE, 10'd0, 1'b0, 8'd0);
    send_command(CMD_RELEASE, 10'h3FF, 1'b1, 8'hFF);
    send_command(CMD_TICK, 10'h2AA, 1'b1, 8'h55);
    send_command(CMD_READ, 10'd0, 1'b0, 8'd0);
    send_command(CMD_READ, 10'd0, 1'b0, 8'd1);
    send_command(CMD_RELEASE, 10'd0, 1'b0, 8'd0);
    send_command(CMD_TICK, 10'h155, 1'b0, 8'hAA);
    send_command(CMD_TICK, 10'd7, 1'b0, 8'd0);
    send_command(CMD_TICK, 10'h3FF, 1'b1, 8'd0);
    drain();

    // Length above store depth, then shorten it while a frame is recording.
    program_capture(16'd1, 9'h1FF, 20'd1);
    send_command(CMD_RELEASE, 10'd0, 1'b0, 8'd0);
    send_command(CMD_TICK, 10'd11, 1'b1, 8'd0);
    send_command(CMD_TICK, 10'd12, 1'b0, 8'd0);
    send_command(CMD_TICK, 10'd13, 1'b0, 8'd0);
    drain();
    program_capture(16'd1, 9'd2, 20'd1);
    send_command(CMD_TICK, 10'd14, 1'b0, 8'd0);
    send_command(CMD_READ, 10'd0, 1'b0, 8'd2);
    send_command(CMD_READ, 10'd0, 1'b0, 8'd3);
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: program_capture(16'd1, 9'd1, 20'hFFFFF);
        1: program_capture(16'hFFFF, 9'd256, 20'd1);
        2: program_capture(16'd3, 9'd256, 20'd7);
        4: program_capture(16'd0, 9'd300, 20'd0);
        8: program_capture(FRAME_PERIOD_RST, FRAME_LENGTH_RST, BLINK_PERIOD_RST);
        default: program_capture(16'($urandom_range(40)), 9'($urandom_range(40)),
                                 20'($urandom_range(30)));
      endcase
      steady_run = (p == 3);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_random_command();
      drain();
      steady_run = 1'b0;
    end

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: triggered_frame_capture_core.f
rtl/tfc_pkg.sv
rtl/tfc_ram.sv
rtl/triggered_frame_capture_core.sv
rtl/tfc_checker.sv
tb/sv/triggered_frame_capture_core_tb.sv
